FILE: hdl/frx_pkg.sv
// ----------------------------------------------------------------------------
// frx_pkg
// Shared types and constants of the trailer length / XOR checksum deframer.
// ----------------------------------------------------------------------------
package frx_pkg;

    localparam logic [7:0] END_CODE_RESET = 8'd10;

    // distance back from the write position to the length byte
    localparam int LEN_BACK = 3;

    localparam int JQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [5:0] byte_position;
        logic [5:0] frame_length;
        logic       last;
    } t_result;

    typedef struct packed {
        logic valid;
        logic pass;
    } t_chk_done;

endpackage

FILE: hdl/frx_fifo.sv
// ----------------------------------------------------------------------------
// frx_fifo
// Small register-based queue with a count output.
// ----------------------------------------------------------------------------
module frx_fifo #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 2,
    localparam int PW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data,
    output logic [CW-1:0]    o_count
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

FILE: hdl/frx_front.sv
// ----------------------------------------------------------------------------
// frx_front
// Byte intake: ring write position, byte count, end code match, check jobs.
// ----------------------------------------------------------------------------
module frx_front import frx_pkg::*; #(
    parameter  int RING_DEPTH = 128,
    localparam int AW         = $clog2(RING_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_rx_byte,
    output logic          o_full,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_job_push,
    output logic [AW-1:0] o_job_wp,
    input  t_chk_done     i_done
);

    logic [7:0]    r_end_code;
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_cnt;
    logic          r_busy;
    logic          accept;
    logic          ring_full;
    logic [AW-1:0] wp_inc;

    assign accept     = i_push && !r_busy;
    assign ring_full  = (r_cnt == AW'(RING_DEPTH - 1));
    assign wp_inc     = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);

    assign o_full     = r_busy;
    assign o_wr_en    = accept;
    assign o_wr_addr  = r_wp;
    assign o_wr_data  = i_rx_byte;
    assign o_job_push = accept && !ring_full && (i_rx_byte == r_end_code);
    assign o_job_wp   = wp_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_code <= END_CODE_RESET;
            r_wp       <= '0;
            r_cnt      <= '0;
            r_busy     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_end_code <= i_cfg_wdata;
            end
            if (accept) begin
                if (ring_full) begin
                    r_wp  <= '0;
                    r_cnt <= '0;
                end else begin
                    r_wp  <= wp_inc;
                    r_cnt <= r_cnt + AW'(1);
                end
            end
            if (o_job_push) begin
                r_busy <= 1'b1;
            end else if (i_done.valid) begin
                r_busy <= 1'b0;
                if (i_done.pass) begin
                    r_cnt <= '0;
                end
            end
        end
    end

endmodule

FILE: hdl/frx_back.sv
// ----------------------------------------------------------------------------
// frx_back
// Ring store and frame checker: reads length, walks the checksum, then
// streams the payload bytes (or one empty last item) into the result queue.
// ----------------------------------------------------------------------------
module frx_back import frx_pkg::*; #(
    parameter  int RING_DEPTH   = 128,
    parameter  int LENGTH_LIMIT = 64,
    localparam int AW           = $clog2(RING_DEPTH),
    localparam int OCW          = $clog2(OQ_DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_en,
    input  logic [AW-1:0]  i_wr_addr,
    input  logic [7:0]     i_wr_data,
    input  logic           i_job_valid,
    input  logic [AW-1:0]  i_job_wp,
    output logic           o_job_pop,
    output logic           o_res_push,
    output t_result        o_res,
    input  logic [OCW-1:0] i_oq_count,
    input  logic           i_oq_full,
    output t_chk_done      o_done
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEN   = 3'd1;
    localparam logic [2:0] S_LENW  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_EMPTY = 3'd5;

    localparam logic [AW:0] DEPTH_X = (AW + 1)'(RING_DEPTH);

    logic [7:0]    r_ring [RING_DEPTH];
    logic [AW:0]   r_hwm;
    logic [7:0]    r_mem_q;
    logic          r_rd_ok;
    logic          r_rd_v;

    logic [2:0]    r_state;
    logic [AW-1:0] r_lp;
    logic [AW-1:0] r_start;
    logic [AW-1:0] r_ptr;
    logic [5:0]    r_len;
    logic [6:0]    r_iss;
    logic [6:0]    r_got;
    logic [7:0]    r_sum;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rdata;
    logic [AW-1:0] start_calc;
    logic [OCW:0]  oq_load;
    logic          len_bad;
    logic          chk_final;
    logic          emit_last;

    function automatic logic [AW-1:0] ring_sub(input logic [AW-1:0] a, input logic [6:0] d);
        logic [AW:0] ax;
        logic [AW:0] dx;
        ax = {1'b0, a};
        dx = (AW + 1)'(d);
        return (ax >= dx) ? AW'(ax - dx) : AW'(ax + DEPTH_X - dx);
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // ring store: entries past the high-water mark were never written and read 0
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ring[i_wr_addr] <= i_wr_data;
        end
        if (rd_en) begin
            r_mem_q <= r_ring[rd_addr];
            r_rd_ok <= ({1'b0, rd_addr} < r_hwm);
        end
    end

    assign rdata      = r_rd_ok ? r_mem_q : 8'd0;
    assign start_calc = ring_sub(r_lp, {1'b0, rdata[5:0]});
    assign oq_load    = {1'b0, i_oq_count} + (OCW + 1)'(r_rd_v);
    assign len_bad    = (rdata >= 8'(LENGTH_LIMIT));
    assign chk_final  = (r_got == ({1'b0, r_len} + 7'd1));
    assign emit_last  = ((r_got + 7'd1) == {1'b0, r_len});

    always_comb begin
        rd_en       = 1'b0;
        rd_addr     = r_ptr;
        o_job_pop   = 1'b0;
        o_res_push  = 1'b0;
        o_res       = '0;
        o_done      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_job_pop = i_job_valid;
            end
            S_LEN: begin
                rd_en   = 1'b1;
                rd_addr = r_lp;
            end
            S_LENW: begin
                if (len_bad) begin
                    o_done.valid = 1'b1;
                end
            end
            S_CHECK: begin
                rd_en = (r_iss != ({1'b0, r_len} + 7'd2));
                if (r_rd_v && chk_final) begin
                    if (rdata != r_sum) begin
                        o_done.valid = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                rd_en = (r_iss != {1'b0, r_len}) && (oq_load < (OCW + 1)'(OQ_DEPTH));
                if (r_rd_v) begin
                    o_res_push          = 1'b1;
                    o_res.payload_byte  = rdata;
                    o_res.byte_position = r_got[5:0];
                    o_res.frame_length  = r_len;
                    o_res.last          = emit_last;
                    if (emit_last) begin
                        o_done.valid = 1'b1;
                        o_done.pass  = 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (!i_oq_full) begin
                    o_res_push   = 1'b1;
                    o_res.last   = 1'b1;
                    o_done.valid = 1'b1;
                    o_done.pass  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hwm   <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_rd_v <= rd_en;
            if (i_wr_en && ({1'b0, i_wr_addr} >= r_hwm)) begin
                r_hwm <= {1'b0, i_wr_addr} + (AW + 1)'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_lp    <= ring_sub(i_job_wp, 7'(LEN_BACK));
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_state <= S_LENW;
                end
                S_LENW: begin
                    if (len_bad) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_len   <= rdata[5:0];
                        r_start <= start_calc;
                        r_ptr   <= start_calc;
                        r_iss   <= '0;
                        r_got   <= '0;
                        r_sum   <= '0;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (rd_en) begin
                        r_ptr <= ring_inc(r_ptr);
                        r_iss <= r_iss + 7'd1;
                    end
                    if (r_rd_v) begin
                        if (chk_final) begin
                            if (rdata != r_sum) begin
                                r_state <= S_IDLE;
                            end else if (r_len == '0) begin
                                r_state <= S_EMPTY;
                            end else begin
                                r_ptr   <= r_start;
                                r_iss   <= '0;
                                r_got   <= '0;
                                r_state <= S_EMIT;
                            end
                        end else begin
                            r_sum <= r_sum ^ rdata;
                            r_got <= r_got + 7'd1;
                        end
                    end
                end
                S_EMIT: begin
                    if (rd_en) begin
                        r_ptr <= ring_inc(r_ptr);
                        r_iss <= r_iss + 7'd1;
                    end
                    if (r_rd_v) begin
                        r_got <= r_got + 7'd1;
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMPTY: begin
                    if (!i_oq_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/xor_length_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// xor_length_frame_receiver_unit
// Deframer for payload / length / XOR / end-code frames held in a byte ring.
// ----------------------------------------------------------------------------
// Input: one received byte per item, accepted when push is high and full low.
// Output: one payload byte per item with its position, frame length and a
//   last flag; the head item is valid while empty is low and taken on pop.
// Config: i_cfg_we writes the end code (10 after reset) with no wait.
// An item that is not the end code, or that fills the ring, is taken and
//   full stays low.
// An end code holds full high while the frame is checked: the length is
//   fetched, then the XOR is walked over the ring read port, then the
//   payload is streamed, one ring read per result.
// Results sit in a 4-entry queue; when the receiver stalls, the payload walk
//   pauses and full stays high until the last result is queued.
// Reset clears all control state; ring entries never written read as zero.
// ----------------------------------------------------------------------------
module xor_length_frame_receiver_unit import frx_pkg::*; #(
    parameter int RING_DEPTH   = 128,
    parameter int LENGTH_LIMIT = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  logic [7:0] i_rx_byte,
    output logic       full,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output logic [7:0] o_payload_byte,
    output logic [5:0] o_byte_position,
    output logic [5:0] o_frame_length,
    output logic       o_last,
    output logic       empty,
    input  logic       pop
);

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int OCW = $clog2(OQ_DEPTH + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          job_push;
    logic [AW-1:0] job_wp;
    logic          job_empty;
    logic          job_pop;
    logic [AW-1:0] job_head;
    t_chk_done     done;
    logic          res_push;
    t_result       res_in;
    t_result       res_out;
    logic [OCW-1:0] oq_count;
    logic          oq_full;

    frx_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_job_push  (job_push),
        .o_job_wp    (job_wp),
        .i_done      (done)
    );

    frx_fifo #(
        .WIDTH (AW),
        .DEPTH (JQ_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_wp),
        .o_full  (),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_head),
        .o_count ()
    );

    frx_back #(
        .RING_DEPTH   (RING_DEPTH),
        .LENGTH_LIMIT (LENGTH_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_job_valid (!job_empty),
        .i_job_wp    (job_head),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .i_oq_count  (oq_count),
        .i_oq_full   (oq_full),
        .o_done      (done)
    );

    frx_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out),
        .o_count (oq_count)
    );

    assign o_payload_byte  = res_out.payload_byte;
    assign o_byte_position = res_out.byte_position;
    assign o_frame_length  = res_out.frame_length;
    assign o_last          = res_out.last;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the trailer length / XOR checksum deframer. Bytes
// go in through the push/full queue port. Each accepted byte is run through
// a local model of the ring, write position and byte count, which queues the
// payload items a good frame must produce. Each item popped from the block
// is compared against the oldest queued item. The stimulus has directed
// cases, a ring wrap and random frame traffic under several end codes. Both
// sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import frx_pkg::*;

    localparam int RING_DEPTH   = 128;
    localparam int LENGTH_LIMIT = 64;
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_CYCLES = 200;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_BAD_LEN,
        FRAME_TRUNCATED
    } frame_kind_e;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic [7:0] i_rx_byte;
    logic       full;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic [7:0] o_payload_byte;
    logic [5:0] o_byte_position;
    logic [5:0] o_frame_length;
    logic       o_last;
    logic       empty;
    logic       pop;

    // model state
    logic [7:0]  ring_model [RING_DEPTH];
    int unsigned model_wr_pos;
    int unsigned model_since_frame;
    logic [7:0]  model_end_code;
    t_result     expected_payload [$];

    logic [7:0]  cur_end_code = END_CODE_RESET;
    logic        tx_idle_en = 1'b1;
    logic        rx_stall_en = 1'b1;
    int unsigned items_sent = 0;
    int unsigned mismatches = 0;

    xor_length_frame_receiver_unit #(
        .RING_DEPTH  (RING_DEPTH),
        .LENGTH_LIMIT(LENGTH_LIMIT)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .i_rx_byte      (i_rx_byte),
        .full           (full),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_payload_byte (o_payload_byte),
        .o_byte_position(o_byte_position),
        .o_frame_length (o_frame_length),
        .o_last         (o_last),
        .empty          (empty),
        .pop            (pop)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("** xor_length_frame_receiver_unit: FAILED **");
        $finish;
    end

    function automatic int unsigned ring_back(input int unsigned offset);
        return (model_wr_pos + RING_DEPTH - offset) % RING_DEPTH;
    endfunction

    function automatic void deframe_byte(input logic [7:0] rx);
        int unsigned len;
        int unsigned start;
        logic [7:0]  sum;
        t_result     res;
        ring_model[model_wr_pos] = rx;
        model_wr_pos = (model_wr_pos + 1) % RING_DEPTH;
        model_since_frame++;
        if (model_since_frame >= RING_DEPTH) begin
            model_since_frame = 0;
            model_wr_pos = 0;
            return;
        end
        if (rx != model_end_code)
            return;
        len = ring_model[ring_back(LEN_BACK)];
        if (len >= LENGTH_LIMIT)
            return;
        start = ring_back(LEN_BACK + len);
        sum = '0;
        for (int i = 0; i <= len; i++)
            sum ^= ring_model[(start + i) % RING_DEPTH];
        if (sum != ring_model[ring_back(LEN_BACK - 1)])
            return;
        model_since_frame = 0;
        if (len == 0) begin
            res = '{payload_byte: '0, byte_position: '0, frame_length: '0, last: 1'b1};
            expected_payload.push_back(res);
            return;
        end
        for (int i = 0; i < len; i++) begin
            res.payload_byte  = ring_model[(start + i) % RING_DEPTH];
            res.byte_position = 6'(i);
            res.frame_length  = 6'(len);
            res.last          = (i + 1 == len);
            expected_payload.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (ring_model[i])
                ring_model[i] = '0;
            model_wr_pos      = 0;
            model_since_frame = 0;
            model_end_code    = END_CODE_RESET;
        end else begin
            if (i_cfg_we)
                model_end_code = i_cfg_wdata;
            if (push && !full)
                deframe_byte(i_rx_byte);
        end
    end

    function automatic void report(input string what, input t_result want, input t_result got);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s: exp %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     $realtime, what, want.payload_byte, want.byte_position,
                     want.frame_length, want.last, got.payload_byte,
                     got.byte_position, got.frame_length, got.last);
        mismatches++;
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && pop && !empty) begin
            got = '{payload_byte: o_payload_byte, byte_position: o_byte_position,
                    frame_length: o_frame_length, last: o_last};
            if (expected_payload.size() == 0) begin
                report("unexpected item", '0, got);
            end else begin
                want = expected_payload.pop_front();
                if (got.payload_byte !== want.payload_byte ||
                    got.byte_position !== want.byte_position ||
                    got.frame_length !== want.frame_length ||
                    got.last !== want.last)
                    report("mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk)
        pop <= !rx_stall_en || ($urandom_range(99) >= 12);

    task automatic send_byte(input logic [7:0] rx);
        if (tx_idle_en && $urandom_range(99) < 12) begin
            push <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (full !== 1'b0);
        items_sent++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do @(posedge i_clk); while (expected_payload.size() != 0);
    endtask

    task automatic write_end_code(input logic [7:0] code);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= code;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        cur_end_code = code;
        @(posedge i_clk);
    endtask

    task automatic send_frame(input int unsigned len, input frame_kind_e kind);
        logic [7:0] sum;
        logic [7:0] rx;
        logic [7:0] len_byte;
        sum = '0;
        for (int i = 0; i < len; i++) begin
            rx = 8'($urandom_range(255));
            sum ^= rx;
            send_byte(rx);
        end
        if (kind == FRAME_TRUNCATED) begin
            send_byte(cur_end_code);
            return;
        end
        len_byte = (kind == FRAME_BAD_LEN) ? 8'($urandom_range(255, LENGTH_LIMIT)) : 8'(len);
        sum ^= len_byte;
        send_byte(len_byte);
        if (kind == FRAME_BAD_SUM)
            sum ^= 8'($urandom_range(255, 1));
        send_byte(sum);
        send_byte(cur_end_code);
    endtask

    // ring still zero from reset reads as a good empty frame
    task automatic test_zero_ring();
        send_byte(cur_end_code);
    endtask

    task automatic test_empty_frame();
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(cur_end_code);
    endtask

    task automatic test_short_frames();
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'hFE);
        send_byte(cur_end_code);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h02);
        send_byte(8'h82);
        send_byte(cur_end_code);
    endtask

    task automatic test_length_too_large();
        send_byte(8'd64);
        send_byte(8'd64);
        send_byte(cur_end_code);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(cur_end_code);
    endtask

    task automatic test_bad_checksum();
        send_frame(1, FRAME_BAD_SUM);
    endtask

    task automatic test_max_frame();
        send_frame(LENGTH_LIMIT - 1, FRAME_GOOD);
    endtask

    // fill the ring with no good frame: the last byte is an end code after
    // a valid empty trailer, but the ring-full reset wins
    task automatic test_ring_wrap();
        logic [7:0]  rx;
        int unsigned fill;
        drain_results();
        fill = RING_DEPTH - 3 - model_since_frame;
        for (int i = 0; i < fill; i++) begin
            do rx = 8'($urandom_range(255)); while (rx == cur_end_code);
            send_byte(rx);
        end
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(cur_end_code);
        send_byte(cur_end_code);
        send_frame(2, FRAME_GOOD);
    endtask

    task automatic test_random_frames(input int unsigned n_items);
        int unsigned first;
        int unsigned pick;
        int unsigned len;
        first = items_sent;
        while (items_sent - first < n_items) begin
            pick = $urandom_range(99);
            len = $urandom_range(99);
            if (len < 80)
                len = $urandom_range(6);
            else if (len < 95)
                len = $urandom_range(20, 7);
            else
                len = $urandom_range(LENGTH_LIMIT - 1, 21);
            if (pick < 70)
                send_frame(len, FRAME_GOOD);
            else if (pick < 80)
                send_frame(len, FRAME_BAD_SUM);
            else if (pick < 86)
                send_frame(len, FRAME_BAD_LEN);
            else if (pick < 93)
                repeat ($urandom_range(5, 1)) send_byte(8'($urandom_range(255)));
            else
                send_frame($urandom_range(4, 1), FRAME_TRUNCATED);
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_rx_byte   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        pop         <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_ring();
        test_empty_frame();
        test_short_frames();
        test_max_frame();
        test_length_too_large();
        test_bad_checksum();

        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        test_ring_wrap();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;

        write_end_code(8'hFF);
        test_random_frames(4);

        write_end_code(8'h00);
        test_random_frames(4);

        write_end_code(8'($urandom_range(254, 1)));
        test_random_frames(4);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_payload.size() == 0)
            $display("** xor_length_frame_receiver_unit: PASSED **");
        else
            $display("** xor_length_frame_receiver_unit: FAILED **");
        $finish;
    end

endmodule

FILE: xor_length_frame_receiver_unit.f
hdl/frx_pkg.sv
hdl/frx_fifo.sv
hdl/frx_front.sv
hdl/frx_back.sv
hdl/xor_length_frame_receiver_unit.sv
bench/tb_top.sv
